/* rtl/rtdm_pkg.sv */
package rtdm_pkg;

    localparam int RAW_BITS = 10;
    localparam int POS_BITS = 12;

    // raw window
    localparam int X_LO = 120;
    localparam int X_HI = 890;
    localparam int Y_LO = 120;
    localparam int Y_HI = 930;
    localparam int SPAN_X = X_HI - X_LO;
    localparam int SPAN_Y = Y_HI - Y_LO;
    localparam int SPAN_MAX = (SPAN_X > SPAN_Y) ? SPAN_X : SPAN_Y;
    localparam int DIFF_BITS = $clog2(SPAN_MAX + 1);
    localparam int PROD_BITS = DIFF_BITS + POS_BITS;

    // reciprocal scaling: estimate is exact or one short
    localparam int RECIP_SHIFT = PROD_BITS;
    localparam longint RECIP_X = (64'd1 << RECIP_SHIFT) / SPAN_X;
    localparam longint RECIP_Y = (64'd1 << RECIP_SHIFT) / SPAN_Y;
    localparam int RECIP_BITS = $clog2(((RECIP_X > RECIP_Y) ? RECIP_X : RECIP_Y) + 1);

    localparam int TIME_BITS  = 32;
    localparam int IVAL_BITS  = 16;
    localparam int DELTA_BITS = 10;
    localparam int SIDE_BITS  = 12;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDLE_MS      = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DEBOUNCE_MS  = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOVE_MS      = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AGREE_DELTA  = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_SIDE   = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_SIDE    = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ORIENTATION  = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EVENT_ENABLE = 4'd7;

    localparam logic [1:0] EV_NONE  = 2'd0;
    localparam logic [1:0] EV_START = 2'd1;
    localparam logic [1:0] EV_MOVE  = 2'd2;
    localparam logic [1:0] EV_END   = 2'd3;

    localparam logic [1:0] ORI_PORTRAIT1  = 2'd0;
    localparam logic [1:0] ORI_PORTRAIT2  = 2'd1;
    localparam logic [1:0] ORI_LANDSCAPE1 = 2'd2;
    localparam logic [1:0] ORI_LANDSCAPE2 = 2'd3;

    localparam int EN_START_BIT = 0;
    localparam int EN_MOVE_BIT  = 1;
    localparam int EN_END_BIT   = 2;

    localparam int Q_DEPTH = 2;

    typedef struct packed {
        logic [IVAL_BITS-1:0]  idle_ms;
        logic [IVAL_BITS-1:0]  debounce_ms;
        logic [IVAL_BITS-1:0]  move_ms;
        logic [DELTA_BITS-1:0] agree_delta;
        logic [2:0]            event_enable;
    } t_timing_cfg;

    typedef struct packed {
        logic [SIDE_BITS-1:0] short_side;
        logic [SIDE_BITS-1:0] long_side;
        logic [1:0]           orientation;
    } t_map_cfg;

    // one classified poll, passed from front to back
    typedef struct packed {
        logic [1:0]          kind;
        logic                map;
        logic [RAW_BITS-1:0] cx;
        logic [RAW_BITS-1:0] cy;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [DIFF_BITS-1:0] clamp_off(input logic [RAW_BITS-1:0] v,
                                                       input int lo, input int hi);
        int vi;
        int r;
        vi = int'(v);
        if (vi < lo) begin
            r = 0;
        end else if (vi > hi) begin
            r = hi - lo;
        end else begin
            r = vi - lo;
        end
        return DIFF_BITS'(r);
    endfunction

endpackage

/* rtl/rtdm_front.sv */
module rtdm_front import rtdm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_timing_cfg         i_cfg,
    input  logic                i_accept,
    input  logic [TIME_BITS-1:0] i_now_ms,
    input  logic                i_pen_down,
    input  logic [RAW_BITS-1:0] i_raw_x,
    input  logic [RAW_BITS-1:0] i_raw_y,
    output t_cmd                o_cmd
);

    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_START       = 3'd1,
        PH_MAYBE_START = 3'd2,
        PH_TOUCHED     = 3'd3,
        PH_MOVING      = 3'd4,
        PH_MAYBE_END   = 3'd5
    } t_phase;

    localparam int CMP_BITS = (RAW_BITS > DELTA_BITS) ? RAW_BITS : DELTA_BITS;

    t_phase               r_phase, n_phase;
    logic [TIME_BITS-1:0] r_last, n_last;
    logic [RAW_BITS-1:0]  r_first_x, n_first_x, r_first_y, n_first_y;
    logic [RAW_BITS-1:0]  r_conf_x, n_conf_x, r_conf_y, n_conf_y;

    logic [TIME_BITS-1:0] since;
    logic                 el_idle, el_deb, el_move;
    logic [CMP_BITS-1:0]  dx, dy, delta;
    logic                 far, near;
    logic [1:0]           kind;
    logic                 map;

    assign since   = i_now_ms - r_last;
    assign el_idle = since > TIME_BITS'(i_cfg.idle_ms);
    assign el_deb  = since > TIME_BITS'(i_cfg.debounce_ms);
    assign el_move = since > TIME_BITS'(i_cfg.move_ms);

    assign dx    = (i_raw_x > r_first_x) ? CMP_BITS'(i_raw_x - r_first_x)
                                         : CMP_BITS'(r_first_x - i_raw_x);
    assign dy    = (i_raw_y > r_first_y) ? CMP_BITS'(i_raw_y - r_first_y)
                                         : CMP_BITS'(r_first_y - i_raw_y);
    assign delta = CMP_BITS'(i_cfg.agree_delta);
    // start check rejects above delta, move check accepts strictly below
    assign far   = (dx > delta) || (dy > delta);
    assign near  = (dx < delta) && (dy < delta);

    always_comb begin
        n_phase   = r_phase;
        n_last    = r_last;
        n_first_x = r_first_x;
        n_first_y = r_first_y;
        n_conf_x  = r_conf_x;
        n_conf_y  = r_conf_y;
        kind      = EV_NONE;
        map       = 1'b0;
        unique case (r_phase)
            PH_START: begin
                if (i_pen_down) begin
                    n_first_x = i_raw_x;
                    n_first_y = i_raw_y;
                    n_phase   = PH_MAYBE_START;
                end
            end
            PH_MAYBE_START: begin
                if (el_deb) begin
                    n_last = i_now_ms;
                    if (!i_pen_down) begin
                        n_phase = PH_START;
                    end else begin
                        n_conf_x = i_raw_x;
                        n_conf_y = i_raw_y;
                        if (far) begin
                            n_phase = PH_START;
                        end else begin
                            n_phase = PH_TOUCHED;
                            if (i_cfg.event_enable[EN_START_BIT]) begin
                                map  = 1'b1;
                                kind = EV_START;
                            end
                        end
                    end
                end
            end
            PH_TOUCHED: begin
                if (!i_pen_down) begin
                    n_phase = PH_MAYBE_END;
                end else if (el_move) begin
                    n_last    = i_now_ms;
                    n_first_x = i_raw_x;
                    n_first_y = i_raw_y;
                    n_phase   = PH_MOVING;
                    if (i_cfg.event_enable[EN_MOVE_BIT]) begin
                        map  = 1'b1;
                        kind = EV_MOVE;
                    end
                end
            end
            PH_MOVING: begin
                if (!i_pen_down) begin
                    n_phase = PH_MAYBE_END;
                end else if (el_deb) begin
                    n_last   = i_now_ms;
                    n_conf_x = i_raw_x;
                    n_conf_y = i_raw_y;
                    n_phase  = PH_TOUCHED;
                    if (i_cfg.event_enable[EN_MOVE_BIT] && near) begin
                        map  = 1'b1;
                        kind = EV_MOVE;
                    end
                end
            end
            PH_MAYBE_END: begin
                if (el_deb) begin
                    n_last = i_now_ms;
                    if (!i_pen_down) begin
                        n_phase = PH_IDLE;
                        if (i_cfg.event_enable[EN_END_BIT]) begin
                            kind = EV_END;
                        end
                    end else begin
                        n_phase = PH_TOUCHED;
                    end
                end
            end
            default: begin
                if (el_idle) begin
                    n_last  = i_now_ms;
                    n_phase = PH_START;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    // mapping uses the confirmed sample as it stands after this poll
    assign o_cmd = '{kind: kind, map: map, cx: n_conf_x, cy: n_conf_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_last    <= '0;
            r_first_x <= '0;
            r_first_y <= '0;
            r_conf_x  <= '0;
            r_conf_y  <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_last    <= n_last;
            r_first_x <= n_first_x;
            r_first_y <= n_first_y;
            r_conf_x  <= n_conf_x;
            r_conf_y  <= n_conf_y;
        end
    end

endmodule

/* rtl/rtdm_queue.sv */
module rtdm_queue import rtdm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd      i_cmd,
    input  logic      i_pop,
    output t_cmd      o_cmd,
    output t_q_status o_status
);

    localparam int PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(Q_DEPTH + 1);

    t_cmd                r_mem [Q_DEPTH];
    logic [PTR_BITS-1:0] r_wr, r_rd;
    logic [CNT_BITS-1:0] r_count;

    function automatic logic [PTR_BITS-1:0] bump(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_cmd          = r_mem[r_rd];
    assign o_status.full  = r_count == CNT_BITS'(Q_DEPTH);
    assign o_status.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= bump(r_wr);
            end
            if (i_pop) begin
                r_rd <= bump(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/rtdm_back.sv */
module rtdm_back import rtdm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_map_cfg            i_cfg,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_event_kind,
    output logic [POS_BITS-1:0] o_pos_x,
    output logic [POS_BITS-1:0] o_pos_y
);

    localparam int EST_BITS = PROD_BITS + RECIP_BITS;

    // stage 1: scaled products
    logic                 r_v1;
    logic [1:0]           r_kind1;
    logic                 r_map1;
    logic [PROD_BITS-1:0] r_px1, r_py1;
    // stage 2: quotient estimates
    logic                 r_v2;
    logic [1:0]           r_kind2;
    logic                 r_map2;
    logic [PROD_BITS-1:0] r_px2, r_py2;
    logic [POS_BITS-1:0]  r_qx2, r_qy2;
    // stage 3: output register and last reported position
    logic                 r_v3;
    logic [1:0]           r_kind3;
    logic [POS_BITS-1:0]  r_pos_x3, r_pos_y3;
    logic [POS_BITS-1:0]  r_rep_x, r_rep_y;

    logic en1, en2, en3;
    logic [DIFF_BITS-1:0] ox, oy;
    logic [EST_BITS-1:0]  est_x, est_y;
    logic [PROD_BITS-1:0] rem_x, rem_y;
    logic [POS_BITS-1:0]  sx, sy, map_x, map_y, out_x, out_y;
    logic [POS_BITS-1:0]  short_s, long_s;

    assign en3       = !r_v3 || i_ready;
    assign en2       = !r_v2 || en3;
    assign en1       = !r_v1 || en2;
    assign o_cmd_pop = i_cmd_valid && en1;

    assign ox = clamp_off(i_cmd.cx, X_LO, X_HI);
    assign oy = clamp_off(i_cmd.cy, Y_LO, Y_HI);

    assign est_x = EST_BITS'(r_px1) * EST_BITS'(RECIP_X);
    assign est_y = EST_BITS'(r_py1) * EST_BITS'(RECIP_Y);

    // one correction step finishes the division
    assign rem_x = r_px2 - PROD_BITS'(PROD_BITS'(r_qx2) * PROD_BITS'(SPAN_X));
    assign rem_y = r_py2 - PROD_BITS'(PROD_BITS'(r_qy2) * PROD_BITS'(SPAN_Y));
    assign sx    = r_qx2 + POS_BITS'(rem_x >= PROD_BITS'(SPAN_X));
    assign sy    = r_qy2 + POS_BITS'(rem_y >= PROD_BITS'(SPAN_Y));

    assign short_s = POS_BITS'(i_cfg.short_side);
    assign long_s  = POS_BITS'(i_cfg.long_side);

    always_comb begin
        unique case (i_cfg.orientation)
            ORI_PORTRAIT1: begin
                map_x = sx;
                map_y = long_s - sy;
            end
            ORI_PORTRAIT2: begin
                map_x = short_s - sx;
                map_y = sy;
            end
            ORI_LANDSCAPE1: begin
                map_x = sy;
                map_y = sx;
            end
            default: begin
                map_x = long_s - sy;
                map_y = short_s - sx;
            end
        endcase
    end

    always_comb begin
        if (r_kind2 == EV_NONE) begin
            out_x = '0;
            out_y = '0;
        end else if (r_map2) begin
            out_x = map_x;
            out_y = map_y;
        end else begin
            out_x = r_rep_x;
            out_y = r_rep_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_kind1 <= i_cmd.kind;
            r_map1  <= i_cmd.map;
            r_px1   <= PROD_BITS'(ox) * PROD_BITS'(i_cfg.short_side);
            r_py1   <= PROD_BITS'(oy) * PROD_BITS'(i_cfg.long_side);
        end
        if (en2) begin
            r_kind2 <= r_kind1;
            r_map2  <= r_map1;
            r_px2   <= r_px1;
            r_py2   <= r_py1;
            r_qx2   <= POS_BITS'(est_x >> RECIP_SHIFT);
            r_qy2   <= POS_BITS'(est_y >> RECIP_SHIFT);
        end
        if (en3) begin
            r_kind3  <= r_kind2;
            r_pos_x3 <= out_x;
            r_pos_y3 <= out_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_rep_x <= '0;
            r_rep_y <= '0;
        end else begin
            if (en1) begin
                r_v1 <= i_cmd_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
                if (r_v2 && r_map2) begin
                    r_rep_x <= map_x;
                    r_rep_y <= map_y;
                end
            end
        end
    end

    assign o_valid      = r_v3;
    assign o_event_kind = r_kind3;
    assign o_pos_x      = r_pos_x3;
    assign o_pos_y      = r_pos_y3;

endmodule

/* rtl/resistive_touch_debounce_mapper.sv */
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+-------------------------------------
// poll     | in        | i_in_valid / o_in_ready   | i_now_ms i_pen_down i_raw_x i_raw_y
// event    | out       | o_out_valid / i_out_ready | o_event_kind o_pos_x o_pos_y
// config   | in        | i_cfg_we                  | i_cfg_index i_cfg_data
//
// one poll per cycle while the queue has room; the phase machine decides each poll combinationally
// an event passes from its poll through the queue, product, quotient estimate and output registers
// synchronous active-low reset, no clearing pass; the control and config registers return to their defaults
// a stalled output fills the three scaling stages, then the two-entry queue, then
// o_in_ready drops
module resistive_touch_debounce_mapper import rtdm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [TIME_BITS-1:0]     i_now_ms,
    input  logic                     i_pen_down,
    input  logic [RAW_BITS-1:0]      i_raw_x,
    input  logic [RAW_BITS-1:0]      i_raw_y,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_event_kind,
    output logic [POS_BITS-1:0]      o_pos_x,
    output logic [POS_BITS-1:0]      o_pos_y
);

    t_timing_cfg r_tcfg;
    t_map_cfg    r_mcfg;
    t_cmd        front_cmd, q_cmd;
    t_q_status   q_status;
    logic        in_accept, q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcfg.idle_ms      <= IVAL_BITS'(20);
            r_tcfg.debounce_ms  <= IVAL_BITS'(5);
            r_tcfg.move_ms      <= IVAL_BITS'(20);
            r_tcfg.agree_delta  <= DELTA_BITS'(10);
            r_tcfg.event_enable <= 3'd7;
            r_mcfg.short_side   <= SIDE_BITS'(240);
            r_mcfg.long_side    <= SIDE_BITS'(320);
            r_mcfg.orientation  <= ORI_PORTRAIT1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IDLE_MS:      r_tcfg.idle_ms      <= i_cfg_data;
                CFG_DEBOUNCE_MS:  r_tcfg.debounce_ms  <= i_cfg_data;
                CFG_MOVE_MS:      r_tcfg.move_ms      <= i_cfg_data;
                CFG_AGREE_DELTA:  r_tcfg.agree_delta  <= i_cfg_data[DELTA_BITS-1:0];
                CFG_SHORT_SIDE:   r_mcfg.short_side   <= i_cfg_data[SIDE_BITS-1:0];
                CFG_LONG_SIDE:    r_mcfg.long_side    <= i_cfg_data[SIDE_BITS-1:0];
                CFG_ORIENTATION:  r_mcfg.orientation  <= i_cfg_data[1:0];
                CFG_EVENT_ENABLE: r_tcfg.event_enable <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = !q_status.full;
    assign in_accept  = i_in_valid && o_in_ready;

    rtdm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_tcfg),
        .i_accept   (in_accept),
        .i_now_ms   (i_now_ms),
        .i_pen_down (i_pen_down),
        .i_raw_x    (i_raw_x),
        .i_raw_y    (i_raw_y),
        .o_cmd      (front_cmd)
    );

    rtdm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (in_accept),
        .i_cmd    (front_cmd),
        .i_pop    (q_pop),
        .o_cmd    (q_cmd),
        .o_status (q_status)
    );

    rtdm_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_mcfg),
        .i_cmd_valid  (!q_status.empty),
        .i_cmd        (q_cmd),
        .o_cmd_pop    (q_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_event_kind (o_event_kind),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y)
    );

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == EV_NONE) |-> (o_pos_x == '0) && (o_pos_y == '0))
        else $error("no-event result carries a position");

    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> !q_status.empty)
        else $error("accepted transaction missing from queue");

    a_reset_quiet: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid && q_status.empty)
        else $error("output or queue busy straight after reset");

endmodule

/* tb/sv/tb_resistive_touch_debounce_mapper.sv */
`timescale 1ns / 100ps

module tb_resistive_touch_debounce_mapper;
    import rtdm_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int NUM_REGS        = CFG_EVENT_ENABLE + 1;
    localparam int N_SETTINGS      = 8;
    localparam int RANDOM_SETTING  = 6;
    localparam int PRESSURE_SETTING = 6;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int HOLD_CYCLES     = 300;
    localparam int STALL_LIMIT     = 4000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RAW_MAX         = (1 << RAW_BITS) - 1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_MAYBE_START,
        PH_TOUCHED,
        PH_MOVING,
        PH_MAYBE_END
    } touch_phase_e;

    typedef struct packed {
        logic [1:0]          kind;
        logic [POS_BITS-1:0] pos_x;
        logic [POS_BITS-1:0] pos_y;
    } touch_event_t;

    class touch_scoreboard;
        bit [IVAL_BITS-1:0]  idle_ms;
        bit [IVAL_BITS-1:0]  debounce_ms;
        bit [IVAL_BITS-1:0]  move_ms;
        bit [DELTA_BITS-1:0] agree_delta;
        bit [SIDE_BITS-1:0]  short_side;
        bit [SIDE_BITS-1:0]  long_side;
        bit [1:0]            orientation;
        bit [2:0]            event_enable;

        touch_phase_e        phase;
        bit [TIME_BITS-1:0]  last_time;
        bit [RAW_BITS-1:0]   first_x, first_y;
        bit [RAW_BITS-1:0]   conf_x, conf_y;
        bit [POS_BITS-1:0]   rep_x, rep_y;

        touch_event_t        pending_events[$];
        int                  mismatches;

        function new();
            idle_ms      = 20;
            debounce_ms  = 5;
            move_ms      = 20;
            agree_delta  = 10;
            short_side   = 240;
            long_side    = 320;
            orientation  = ORI_PORTRAIT1;
            event_enable = 3'b111;
            phase        = PH_IDLE;
            last_time    = '0;
            first_x      = '0;
            first_y      = '0;
            conf_x       = '0;
            conf_y       = '0;
            rep_x        = '0;
            rep_y        = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                CFG_IDLE_MS:      idle_ms      = data;
                CFG_DEBOUNCE_MS:  debounce_ms  = data;
                CFG_MOVE_MS:      move_ms      = data;
                CFG_AGREE_DELTA:  agree_delta  = data[DELTA_BITS-1:0];
                CFG_SHORT_SIDE:   short_side   = data[SIDE_BITS-1:0];
                CFG_LONG_SIDE:    long_side    = data[SIDE_BITS-1:0];
                CFG_ORIENTATION:  orientation  = data[1:0];
                CFG_EVENT_ENABLE: event_enable = data[2:0];
                default: ;
            endcase
        endfunction

        function bit waited(bit [TIME_BITS-1:0] now, bit [TIME_BITS-1:0] span);
            return (now - last_time) > span;
        endfunction

        function int unsigned raw_gap(bit [RAW_BITS-1:0] a, bit [RAW_BITS-1:0] b);
            return (a > b) ? a - b : b - a;
        endfunction

        // confirmed sample clamped to the window, scaled, then rotated
        function void scale_position();
            int unsigned off_x, off_y, sx, sy, px, py;
            off_x = (conf_x < X_LO) ? 0 : (conf_x > X_HI) ? SPAN_X : conf_x - X_LO;
            off_y = (conf_y < Y_LO) ? 0 : (conf_y > Y_HI) ? SPAN_Y : conf_y - Y_LO;
            sx = off_x * short_side / SPAN_X;
            sy = off_y * long_side / SPAN_Y;
            case (orientation)
                ORI_PORTRAIT1: begin
                    px = sx;
                    py = long_side - sy;
                end
                ORI_PORTRAIT2: begin
                    px = short_side - sx;
                    py = sy;
                end
                ORI_LANDSCAPE1: begin
                    px = sy;
                    py = sx;
                end
                default: begin
                    px = long_side - sy;
                    py = short_side - sx;
                end
            endcase
            rep_x = POS_BITS'(px);
            rep_y = POS_BITS'(py);
        endfunction

        function void note_poll(bit [TIME_BITS-1:0] now, bit pen,
                                bit [RAW_BITS-1:0] rx, bit [RAW_BITS-1:0] ry);
            touch_event_t ev;
            ev = '0;
            ev.kind = EV_NONE;
            case (phase)
                PH_START: begin
                    if (pen) begin
                        first_x = rx;
                        first_y = ry;
                        phase = PH_MAYBE_START;
                    end
                end
                PH_MAYBE_START: begin
                    // timer still runs from the end of the idle wait
                    if (waited(now, debounce_ms)) begin
                        last_time = now;
                        if (!pen) begin
                            phase = PH_START;
                        end else begin
                            conf_x = rx;
                            conf_y = ry;
                            if (raw_gap(rx, first_x) > agree_delta ||
                                raw_gap(ry, first_y) > agree_delta) begin
                                phase = PH_START;
                            end else begin
                                phase = PH_TOUCHED;
                                if (event_enable[EN_START_BIT]) begin
                                    scale_position();
                                    ev.kind = EV_START;
                                end
                            end
                        end
                    end
                end
                PH_TOUCHED: begin
                    if (!pen) begin
                        phase = PH_MAYBE_END;
                    end else if (waited(now, move_ms)) begin
                        last_time = now;
                        first_x = rx;
                        first_y = ry;
                        phase = PH_MOVING;
                        // reports the previously agreed position
                        if (event_enable[EN_MOVE_BIT]) begin
                            scale_position();
                            ev.kind = EV_MOVE;
                        end
                    end
                end
                PH_MOVING: begin
                    if (!pen) begin
                        phase = PH_MAYBE_END;
                    end else if (waited(now, debounce_ms)) begin
                        last_time = now;
                        conf_x = rx;
                        conf_y = ry;
                        if (event_enable[EN_MOVE_BIT] && raw_gap(rx, first_x) < agree_delta &&
                            raw_gap(ry, first_y) < agree_delta) begin
                            scale_position();
                            ev.kind = EV_MOVE;
                        end
                        phase = PH_TOUCHED;
                    end
                end
                PH_MAYBE_END: begin
                    if (waited(now, debounce_ms)) begin
                        last_time = now;
                        if (!pen) begin
                            phase = PH_IDLE;
                            if (event_enable[EN_END_BIT]) ev.kind = EV_END;
                        end else begin
                            phase = PH_TOUCHED;
                        end
                    end
                end
                default: begin
                    if (waited(now, idle_ms)) begin
                        last_time = now;
                        phase = PH_START;
                    end else begin
                        phase = PH_IDLE;
                    end
                end
            endcase
            if (ev.kind != EV_NONE) begin
                ev.pos_x = rep_x;
                ev.pos_y = rep_y;
            end
            pending_events.push_back(ev);
        endfunction

        function void check_event(logic [1:0] kind, logic [POS_BITS-1:0] px,
                                  logic [POS_BITS-1:0] py);
            touch_event_t want;
            if (pending_events.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected event: kind %0d x %0d y %0d", kind, px, py);
                mismatches++;
                return;
            end
            want = pending_events.pop_front();
            if (want.kind !== kind || want.pos_x !== px || want.pos_y !== py) begin
                if (mismatches < 10)
                    $display({"event mismatch: expected kind %0d x %0d y %0d, ",
                              "got kind %0d x %0d y %0d"},
                             want.kind, want.pos_x, want.pos_y, kind, px, py);
                mismatches++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [TIME_BITS-1:0]     i_now_ms = '0;
    logic                     i_pen_down = 1'b0;
    logic [RAW_BITS-1:0]      i_raw_x = '0;
    logic [RAW_BITS-1:0]      i_raw_y = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [1:0]               o_event_kind;
    logic [POS_BITS-1:0]      o_pos_x;
    logic [POS_BITS-1:0]      o_pos_y;

    touch_scoreboard board = new();

    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 holds_asked = 0;
    int                 holds_done = 0;
    int                 hold_left = 0;
    int                 quiet_cycles = 0;
    int                 polls_sent = 0;
    bit [TIME_BITS-1:0] clock_ms = '0;
    int unsigned        setting [N_SETTINGS][NUM_REGS];

    resistive_touch_debounce_mapper dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_now_ms     (i_now_ms),
        .i_pen_down   (i_pen_down),
        .i_raw_x      (i_raw_x),
        .i_raw_y      (i_raw_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_event_kind (o_event_kind),
        .o_pos_x      (o_pos_x),
        .o_pos_y      (o_pos_y)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // event side: random stalls, plus a long hold-off when asked for
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            board.check_event(o_event_kind, o_pos_x, o_pos_y);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit [RAW_BITS-1:0] raw_clip(int v);
        if (v < 0) return '0;
        if (v > RAW_MAX) return RAW_BITS'(RAW_MAX);
        return RAW_BITS'(v);
    endfunction

    // next poll time, scaled to whatever interval the machine is waiting out
    function automatic bit [TIME_BITS-1:0] next_time();
        int unsigned span;
        int          r;
        case (board.phase)
            PH_IDLE:    span = board.idle_ms;
            PH_START:   span = 0;
            PH_TOUCHED: span = board.move_ms;
            default:    span = board.debounce_ms;
        endcase
        r = $urandom_range(0, 99);
        if (r < 3) return $urandom;
        if (r < 8) return clock_ms;
        if (r < 14) return board.last_time + span;
        if (r < 18) return board.last_time + span + 1;
        return clock_ms + $urandom_range(0, span / 2 + 2);
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_poll(input bit [TIME_BITS-1:0] t, input bit pen,
                             input bit [RAW_BITS-1:0] rx, input bit [RAW_BITS-1:0] ry);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_now_ms   <= t;
        i_pen_down <= pen;
        i_raw_x    <= rx;
        i_raw_y    <= ry;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        board.note_poll(t, pen, rx, ry);
        polls_sent++;
        @(negedge i_clk);
    endtask

    task automatic poll(input bit pen, input int x, input int y);
        clock_ms = next_time();
        send_poll(clock_ms, pen, raw_clip(x), raw_clip(y));
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_BITS-1:0];
        board.write_reg(idx, val[CFG_DATA_BITS-1:0]);
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (board.pending_events.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // mostly whole press/hold/release gestures, some random noise
    task automatic run_random(input int n_items);
        int target, bx, by, j;
        target = polls_sent + n_items;
        while (polls_sent < target) begin
            if ($urandom_range(0, 99) < 80) begin
                repeat ($urandom_range(1, 6))
                    poll(1'b0, $urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX));
                bx = $urandom_range(0, RAW_MAX);
                by = $urandom_range(0, RAW_MAX);
                repeat ($urandom_range(2, 30)) begin
                    if ($urandom_range(0, 9) == 0)
                        j = $urandom_range(0, RAW_MAX);
                    else
                        j = $urandom_range(0, board.agree_delta / 2 + 1);
                    if ($urandom_range(0, 7) == 0) begin
                        bx = bx + int'($urandom_range(0, 40)) - 20;
                        by = by + int'($urandom_range(0, 40)) - 20;
                    end
                    poll($urandom_range(0, 19) != 0,
                         bx + int'($urandom_range(0, 2 * j)) - j,
                         by + int'($urandom_range(0, 2 * j)) - j);
                end
                repeat ($urandom_range(1, 8))
                    poll($urandom_range(0, 9) == 0,
                         $urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX));
            end else begin
                repeat ($urandom_range(1, 5))
                    poll($urandom_range(0, 1),
                         $urandom_range(0, RAW_MAX), $urandom_range(0, RAW_MAX));
            end
        end
    endtask

    initial begin
        setting = '{
            '{20, 5, 20, 10, 240, 320, ORI_PORTRAIT1, 3'b111},
            '{0, 0, 0, 0, 1, 1, ORI_PORTRAIT2, 3'b111},
            '{65535, 65535, 65535, 1023, 4095, 4095, ORI_LANDSCAPE1, 3'b111},
            '{3, 2, 8, 30, 480, 800, ORI_LANDSCAPE2, 3'b101},
            '{10, 4, 12, 15, 0, 4095, ORI_PORTRAIT1, 3'b011},
            '{7, 3, 9, 20, 4095, 0, ORI_LANDSCAPE2, 3'b110},
            '{0, 0, 0, 0, 0, 0, ORI_PORTRAIT1, 3'b000},
            '{15, 5, 15, 12, 320, 480, ORI_LANDSCAPE1, 3'b111}
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 10;
        recv_idle_pct = 76;

        // reset settings: idle boundary, clamped start, moves, end,
        // then a rejected start and a bounce back to touched
        send_poll(0,   1'b0, 0,    0);
        send_poll(20,  1'b0, 0,    0);
        send_poll(21,  1'b0, 0,    0);
        send_poll(22,  1'b1, 1023, 0);
        send_poll(26,  1'b1, 1023, 0);
        send_poll(27,  1'b1, 1020, 10);
        send_poll(47,  1'b1, 500,  500);
        send_poll(48,  1'b1, 500,  500);
        send_poll(53,  1'b1, 505,  495);
        send_poll(54,  1'b1, 509,  491);
        send_poll(75,  1'b1, 600,  600);
        send_poll(81,  1'b1, 610,  600);
        send_poll(90,  1'b0, 0,    0);
        send_poll(96,  1'b0, 0,    0);
        send_poll(200, 1'b0, 0,    0);
        send_poll(201, 1'b1, 0,    1023);
        send_poll(210, 1'b1, 50,   1023);
        send_poll(211, 1'b0, 0,    1023);
        send_poll(212, 1'b1, 0,    1023);
        send_poll(213, 1'b1, 0,    1023);
        send_poll(216, 1'b1, 0,    1023);
        send_poll(217, 1'b0, 1023, 1023);
        send_poll(220, 1'b1, 1023, 1023);
        send_poll(223, 1'b1, 1023, 1023);
        i_in_valid <= 1'b0;
        clock_ms = 223;

        for (int p = 0; p < N_SETTINGS; p++) begin
            drain();
            if (p == RANDOM_SETTING) begin
                setting[p][CFG_IDLE_MS]      = $urandom_range(0, 40);
                setting[p][CFG_DEBOUNCE_MS]  = $urandom_range(0, 15);
                setting[p][CFG_MOVE_MS]      = $urandom_range(0, 40);
                setting[p][CFG_AGREE_DELTA]  = $urandom_range(0, RAW_MAX);
                setting[p][CFG_SHORT_SIDE]   = $urandom_range(1, 4095);
                setting[p][CFG_LONG_SIDE]    = $urandom_range(1, 4095);
                setting[p][CFG_ORIENTATION]  = $urandom_range(0, 3);
                setting[p][CFG_EVENT_ENABLE] = $urandom_range(0, 7);
            end
            for (int r = 0; r < NUM_REGS; r++)
                write_reg(CFG_IDX_BITS'(r), setting[p][r]);
            i_cfg_we <= 1'b0;

            if (p < 3) begin
                send_idle_pct = 10;
                recv_idle_pct = 76;
            end else if (p < 6) begin
                send_idle_pct = 76;
                recv_idle_pct = 10;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // output held off while polls keep coming, so the input backs up
            if (p == PRESSURE_SETTING) holds_asked++;
            if (p > 0) clock_ms = $urandom;

            run_random(ITEMS_PER_PHASE);
            i_in_valid <= 1'b0;
        end

        drain();
        if (board.mismatches == 0 && board.pending_events.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
